// ===== rtl/core/bcw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcw_pkg
// Shared widths, constants and payload types of the barycentric weights core.
// ----------------------------------------------------------------------------
package bcw_pkg;

  localparam int PIX_W      = 11;
  localparam int CRD_W      = 16;
  localparam int CFRAC      = 4;
  localparam int WFRAC      = 14;
  localparam int OUT_W      = 18;
  localparam int DIFF_W     = CRD_W + 2;
  localparam int PROD_W     = 2 * DIFF_W;
  localparam int CRS_W      = PROD_W + 1;
  localparam int MAG_W      = CRS_W;
  localparam int QB         = OUT_W;
  localparam int N_W        = MAG_W + WFRAC;
  localparam int OVF_SH     = QB - WFRAC;
  localparam int IN_DATA_W  = 120;
  localparam int OUT_DATA_W = 56;

  typedef struct packed {
    logic [CRD_W-1:0] vertex_c_y;
    logic [CRD_W-1:0] vertex_c_x;
    logic [CRD_W-1:0] vertex_b_y;
    logic [CRD_W-1:0] vertex_b_x;
    logic [CRD_W-1:0] vertex_a_y;
    logic [CRD_W-1:0] vertex_a_x;
    logic [PIX_W-1:0] pixel_y;
    logic [PIX_W-1:0] pixel_x;
  } bcw_in_t;

  typedef struct packed {
    logic                    vld;
    logic signed [CRS_W-1:0] den;
    logic signed [CRS_W-1:0] unum;
    logic signed [CRS_W-1:0] vnum;
  } bcw_crs_t;

  typedef struct packed {
    logic            vld;
    logic            dg;
    logic            nu;
    logic            nv;
    logic            ou;
    logic            ov;
    logic [QB-1:0]   qu;
    logic [QB-1:0]   qv;
  } bcw_quo_t;

endpackage

// ===== rtl/core/bcw_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcw_front
// Edge vectors, products and cross products over three register stages.
// ----------------------------------------------------------------------------
module bcw_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_vld,
  input  bcw_pkg::bcw_in_t in_data,
  output bcw_pkg::bcw_crs_t crs
);

  logic                                 s1_vld_r;
  logic signed [bcw_pkg::DIFF_W-1:0]    qx_r, qy_r, e0x_r, e0y_r, e1x_r, e1y_r;
  logic signed [bcw_pkg::DIFF_W-1:0]    px, py, ax, ay, bx, by, cx, cy;
  logic                                 s2_vld_r;
  logic signed [bcw_pkg::PROD_W-1:0]    p_d0_r, p_d1_r, p_u0_r, p_u1_r, p_v0_r, p_v1_r;
  bcw_pkg::bcw_crs_t                    crs_r;

  always_comb begin
    px = $signed({3'b000, in_data.pixel_x, {bcw_pkg::CFRAC{1'b0}}}) ;
    py = $signed({3'b000, in_data.pixel_y, {bcw_pkg::CFRAC{1'b0}}}) ;
    ax = $signed({{2{in_data.vertex_a_x[bcw_pkg::CRD_W-1]}}, in_data.vertex_a_x});
    ay = $signed({{2{in_data.vertex_a_y[bcw_pkg::CRD_W-1]}}, in_data.vertex_a_y});
    bx = $signed({{2{in_data.vertex_b_x[bcw_pkg::CRD_W-1]}}, in_data.vertex_b_x});
    by = $signed({{2{in_data.vertex_b_y[bcw_pkg::CRD_W-1]}}, in_data.vertex_b_y});
    cx = $signed({{2{in_data.vertex_c_x[bcw_pkg::CRD_W-1]}}, in_data.vertex_c_x});
    cy = $signed({{2{in_data.vertex_c_y[bcw_pkg::CRD_W-1]}}, in_data.vertex_c_y});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r  <= in_vld;
      s2_vld_r  <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qx_r  <= px - ax;
      qy_r  <= py - ay;
      e0x_r <= bx - ax;
      e0y_r <= by - ay;
      e1x_r <= cx - ax;
      e1y_r <= cy - ay;
      p_d0_r <= e0x_r * e1y_r;
      p_d1_r <= e0y_r * e1x_r;
      p_u0_r <= qx_r * e1y_r;
      p_u1_r <= qy_r * e1x_r;
      p_v0_r <= e0x_r * qy_r;
      p_v1_r <= e0y_r * qx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crs_r.vld <= 1'b0;
    end else if (en) begin
      crs_r.vld  <= s2_vld_r;
      crs_r.den  <= {p_d0_r[bcw_pkg::PROD_W-1], p_d0_r} - {p_d1_r[bcw_pkg::PROD_W-1], p_d1_r};
      crs_r.unum <= {p_u0_r[bcw_pkg::PROD_W-1], p_u0_r} - {p_u1_r[bcw_pkg::PROD_W-1], p_u1_r};
      crs_r.vnum <= {p_v0_r[bcw_pkg::PROD_W-1], p_v0_r} - {p_v1_r[bcw_pkg::PROD_W-1], p_v1_r};
    end
  end

  assign crs = crs_r;

endmodule

// ===== rtl/core/bcw_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcw_div
// Two-lane pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module bcw_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  bcw_pkg::bcw_crs_t  crs,
  output bcw_pkg::bcw_quo_t  quo
);

  typedef struct packed {
    logic                         vld;
    logic                         dg;
    logic                         nu;
    logic                         nv;
    logic                         ou;
    logic                         ov;
    logic [bcw_pkg::N_W-1:0]      ru;
    logic [bcw_pkg::N_W-1:0]      rv;
    logic [bcw_pkg::QB-1:0]       qu;
    logic [bcw_pkg::QB-1:0]       qv;
    logic [bcw_pkg::MAG_W-1:0]    d;
  } dstage_t;

  // sign / magnitude stage
  logic                         m_vld_r, m_dg_r, m_nu_r, m_nv_r;
  logic [bcw_pkg::MAG_W-1:0]    m_nu_mag_r, m_nv_mag_r, m_d_r;
  dstage_t                      st_r [0:bcw_pkg::QB];
  logic [bcw_pkg::MAG_W+bcw_pkg::OVF_SH-1:0] d_sh;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
    end else if (en) begin
      m_vld_r <= crs.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_dg_r     <= (crs.den == '0);
      m_nu_r     <= crs.unum[bcw_pkg::CRS_W-1] ^ crs.den[bcw_pkg::CRS_W-1];
      m_nv_r     <= crs.vnum[bcw_pkg::CRS_W-1] ^ crs.den[bcw_pkg::CRS_W-1];
      m_nu_mag_r <= crs.unum[bcw_pkg::CRS_W-1] ? -crs.unum : crs.unum;
      m_nv_mag_r <= crs.vnum[bcw_pkg::CRS_W-1] ? -crs.vnum : crs.vnum;
      m_d_r      <= crs.den[bcw_pkg::CRS_W-1] ? -crs.den : crs.den;
    end
  end

  assign d_sh = {m_d_r, {bcw_pkg::OVF_SH{1'b0}}};

  // overflow check and dividend load
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r[0].vld <= 1'b0;
    end else if (en) begin
      st_r[0].vld <= m_vld_r;
      st_r[0].dg <= m_dg_r;
      st_r[0].nu <= m_nu_r;
      st_r[0].nv <= m_nv_r;
      st_r[0].ou <= ({{bcw_pkg::OVF_SH{1'b0}}, m_nu_mag_r} >= d_sh);
      st_r[0].ov <= ({{bcw_pkg::OVF_SH{1'b0}}, m_nv_mag_r} >= d_sh);
      st_r[0].ru <= {m_nu_mag_r, {bcw_pkg::WFRAC{1'b0}}};
      st_r[0].rv <= {m_nv_mag_r, {bcw_pkg::WFRAC{1'b0}}};
      st_r[0].qu <= '0;
      st_r[0].qv <= '0;
      st_r[0].d  <= m_d_r;
    end
  end

  for (genvar k = 0; k < bcw_pkg::QB; k++) begin : g_step
    localparam int BI = bcw_pkg::QB - 1 - k;
    dstage_t                 nxt;
    logic [bcw_pkg::N_W-1:0] dext;
    logic [bcw_pkg::N_W-1:0] dsh;

    always_comb begin
      dext = {{(bcw_pkg::N_W-bcw_pkg::MAG_W){1'b0}}, st_r[k].d};
      dsh  = dext << BI;
      nxt  = st_r[k];
      if ((st_r[k].ru >> BI) >= dext) begin
        nxt.ru     = st_r[k].ru - dsh;
        nxt.qu[BI] = 1'b1;
      end
      if ((st_r[k].rv >> BI) >= dext) begin
        nxt.rv     = st_r[k].rv - dsh;
        nxt.qv[BI] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        st_r[k+1].vld <= 1'b0;
      end else if (en) begin
        st_r[k+1] <= nxt;
      end
    end
  end

  always_comb begin
    quo.vld = st_r[bcw_pkg::QB].vld;
    quo.dg  = st_r[bcw_pkg::QB].dg;
    quo.nu  = st_r[bcw_pkg::QB].nu;
    quo.nv  = st_r[bcw_pkg::QB].nv;
    quo.ou  = st_r[bcw_pkg::QB].ou;
    quo.ov  = st_r[bcw_pkg::QB].ov;
    quo.qu  = st_r[bcw_pkg::QB].qu;
    quo.qv  = st_r[bcw_pkg::QB].qv;
  end

endmodule

// ===== rtl/core/bcw_out.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcw_out
// Signs and saturates u and v, forms the weight of A and holds the result.
// ----------------------------------------------------------------------------
module bcw_out (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  bcw_pkg::bcw_quo_t               quo,
  output logic                            vld,
  output logic signed [bcw_pkg::OUT_W-1:0] wa,
  output logic signed [bcw_pkg::OUT_W-1:0] wb,
  output logic signed [bcw_pkg::OUT_W-1:0] wc,
  output logic                            dg
);

  localparam logic [bcw_pkg::QB-1:0] POS_MAX = {1'b0, {(bcw_pkg::QB-1){1'b1}}};
  localparam logic [bcw_pkg::QB-1:0] NEG_MAG = {1'b1, {(bcw_pkg::QB-1){1'b0}}};
  localparam int SUM_W = bcw_pkg::OUT_W + 2;
  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(signed'(POS_MAX));
  localparam logic signed [SUM_W-1:0] SAT_LO = -SUM_W'(signed'({1'b0, NEG_MAG}));
  localparam logic signed [SUM_W-1:0] ONE    = SUM_W'(1) <<< bcw_pkg::WFRAC;

  logic                             a_vld_r, a_dg_r;
  logic signed [bcw_pkg::OUT_W-1:0] a_wb_r, a_wc_r, a_wb_nxt, a_wc_nxt;
  logic                             o_vld_r, o_dg_r;
  logic signed [bcw_pkg::OUT_W-1:0] o_wa_r, o_wb_r, o_wc_r;
  logic signed [SUM_W-1:0]          wa_full;
  logic signed [bcw_pkg::OUT_W-1:0] wa_nxt;

  always_comb begin
    if (quo.nu) begin
      a_wb_nxt = (quo.ou || quo.qu > NEG_MAG) ? $signed(NEG_MAG) : -$signed(quo.qu);
    end else begin
      a_wb_nxt = (quo.ou || quo.qu > POS_MAX) ? $signed(POS_MAX) : $signed(quo.qu);
    end
    if (quo.nv) begin
      a_wc_nxt = (quo.ov || quo.qv > NEG_MAG) ? $signed(NEG_MAG) : -$signed(quo.qv);
    end else begin
      a_wc_nxt = (quo.ov || quo.qv > POS_MAX) ? $signed(POS_MAX) : $signed(quo.qv);
    end
    if (quo.dg) begin
      a_wb_nxt = '0;
      a_wc_nxt = '0;
    end
  end

  always_comb begin
    wa_full = ONE - (SUM_W'(a_wb_r) + SUM_W'(a_wc_r));
    if (wa_full > SAT_HI) begin
      wa_nxt = bcw_pkg::OUT_W'(SAT_HI);
    end else if (wa_full < SAT_LO) begin
      wa_nxt = bcw_pkg::OUT_W'(SAT_LO);
    end else begin
      wa_nxt = bcw_pkg::OUT_W'(wa_full);
    end
    if (a_dg_r) begin
      wa_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      o_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= quo.vld;
      o_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_dg_r <= quo.dg;
      a_wb_r <= a_wb_nxt;
      a_wc_r <= a_wc_nxt;
      o_dg_r <= a_dg_r;
      o_wb_r <= a_wb_r;
      o_wc_r <= a_wc_r;
      o_wa_r <= wa_nxt;
    end
  end

  assign vld = o_vld_r;
  assign wa  = o_wa_r;
  assign wb  = o_wb_r;
  assign wc  = o_wc_r;
  assign dg  = o_dg_r;

endmodule

// ===== rtl/core/barycentric_weights_core.sv =====
`timescale 1ns / 1ps
// throughput: one word per cycle unless stalled; the divider's 18 step stages retire one quotient bit each
// the whole pipeline holds while an output word waits and out_tready is low
// reset: synchronous active-low rst_n clears all stage valid bits, no output pending
// ----------------------------------------------------------------------------
// barycentric_weights_core
// Barycentric weights of an integer pixel against a fixed-point screen triangle.
// ----------------------------------------------------------------------------
module barycentric_weights_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // pixel_x, pixel_y, vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y,
  // vertex_c_x, vertex_c_y, zero pad
  input  logic [bcw_pkg::IN_DATA_W-1:0]      in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // weight_a, weight_b, weight_c, zero pad
  output logic [bcw_pkg::OUT_DATA_W-1:0]     out_tdata,
  // degenerate
  output logic                               out_tuser
);

  logic                             en;
  bcw_pkg::bcw_in_t                 in_data;
  bcw_pkg::bcw_crs_t                crs;
  bcw_pkg::bcw_quo_t                quo;
  logic signed [bcw_pkg::OUT_W-1:0] wa, wb, wc;
  logic                             dg;

  assign en        = out_tready || !out_tvalid;
  assign in_tready = en;
  assign in_data   = bcw_pkg::bcw_in_t'(in_tdata[$bits(bcw_pkg::bcw_in_t)-1:0]);

  bcw_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (in_tvalid),
    .in_data (in_data),
    .crs     (crs)
  );

  bcw_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .crs   (crs),
    .quo   (quo)
  );

  bcw_out u_out (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .quo   (quo),
    .vld   (out_tvalid),
    .wa    (wa),
    .wb    (wb),
    .wc    (wc),
    .dg    (dg)
  );

  assign out_tdata = {2'b00, wc, wb, wa};
  assign out_tuser = dg;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for barycentric_weights_core: pixel/triangle words are
// queued, streamed with random gaps and back-pressure, and every output word is
// compared with weights computed here from exact 64-bit cross products.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int OMAX = 131071;
  localparam int OMIN = -131072;
  localparam longint CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic signed [bcw_pkg::OUT_W-1:0] wa;
    logic signed [bcw_pkg::OUT_W-1:0] wb;
    logic signed [bcw_pkg::OUT_W-1:0] wc;
    logic                             degen;
  } weights_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [bcw_pkg::IN_DATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [bcw_pkg::OUT_DATA_W-1:0] out_tdata;
  logic out_tuser;

  barycentric_weights_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  bcw_pkg::bcw_in_t pixel_q[$];
  weights_t weights_q[$];
  int  mismatches = 0;
  bit  quiet_tail = 1'b0;
  bit  hold_sink = 1'b0;
  bit  hold_src = 1'b0;
  longint cycles = 0;

  function automatic longint sat_out(longint x);
    if (x > OMAX) return OMAX;
    if (x < OMIN) return OMIN;
    return x;
  endfunction

  function automatic longint fixed_quot(longint num, longint den);
    bit neg;
    longint n, d, q;
    neg = (num < 0) != (den < 0);
    n = (num < 0) ? -num : num;
    d = (den < 0) ? -den : den;
    q = (n <<< bcw_pkg::WFRAC) / d;
    if (neg) return (q > 131072) ? OMIN : -q;
    return (q > OMAX) ? OMAX : q;
  endfunction

  function automatic weights_t predict_weights(bcw_pkg::bcw_in_t p);
    longint px, py, ax, ay, bx, by, cx, cy, den, un, vn, wa, wb, wc;
    weights_t r;
    px = longint'(p.pixel_x) <<< bcw_pkg::CFRAC;
    py = longint'(p.pixel_y) <<< bcw_pkg::CFRAC;
    ax = longint'($signed(p.vertex_a_x)); ay = longint'($signed(p.vertex_a_y));
    bx = longint'($signed(p.vertex_b_x)); by = longint'($signed(p.vertex_b_y));
    cx = longint'($signed(p.vertex_c_x)); cy = longint'($signed(p.vertex_c_y));
    den = (bx - ax) * (cy - ay) - (by - ay) * (cx - ax);
    un = (px - ax) * (cy - ay) - (py - ay) * (cx - ax);
    vn = (bx - ax) * (py - ay) - (by - ay) * (px - ax);
    r = '0;
    if (den == 0) begin
      r.degen = 1'b1;
    end else begin
      wb = fixed_quot(un, den);
      wc = fixed_quot(vn, den);
      wa = sat_out((longint'(1) <<< bcw_pkg::WFRAC) - (wb + wc));
      r.wb = wb[bcw_pkg::OUT_W-1:0];
      r.wc = wc[bcw_pkg::OUT_W-1:0];
      r.wa = wa[bcw_pkg::OUT_W-1:0];
    end
    return r;
  endfunction

  function automatic bcw_pkg::bcw_in_t make_pixel(int px, int py, int ax, int ay,
                                                  int bx, int by, int cx, int cy);
    bcw_pkg::bcw_in_t p;
    p.pixel_x = px[bcw_pkg::PIX_W-1:0]; p.pixel_y = py[bcw_pkg::PIX_W-1:0];
    p.vertex_a_x = ax[bcw_pkg::CRD_W-1:0]; p.vertex_a_y = ay[bcw_pkg::CRD_W-1:0];
    p.vertex_b_x = bx[bcw_pkg::CRD_W-1:0]; p.vertex_b_y = by[bcw_pkg::CRD_W-1:0];
    p.vertex_c_x = cx[bcw_pkg::CRD_W-1:0]; p.vertex_c_y = cy[bcw_pkg::CRD_W-1:0];
    return p;
  endfunction

  // small screen triangle around a pixel, often covering it
  function automatic bcw_pkg::bcw_in_t rand_tri_pixel();
    int px, py, cxp, cyp, sp;
    px = $urandom_range(0, 2047);
    py = $urandom_range(0, 2047);
    sp = $urandom_range(1, 400);
    cxp = px * 16;
    cyp = py * 16;
    return make_pixel(px, py,
      cxp + $urandom_range(0, 2 * sp) - sp, cyp + $urandom_range(0, 2 * sp) - sp,
      cxp + $urandom_range(0, 2 * sp) - sp, cyp + $urandom_range(0, 2 * sp) - sp,
      cxp + $urandom_range(0, 2 * sp) - sp, cyp + $urandom_range(0, 2 * sp) - sp);
  endfunction

  // driver: the front of pixel_q is the word on offer until it is accepted
  int src_gap = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !in_tready) begin
      // hold the offered word
    end else begin
      if (in_tvalid) void'(pixel_q.pop_front());
      if (src_gap > 0) begin
        src_gap <= src_gap - 1;
        in_tvalid <= 1'b0;
      end else if (hold_src || pixel_q.size() == 0) begin
        in_tvalid <= 1'b0;
      end else begin
        in_tdata <= bcw_pkg::IN_DATA_W'(pixel_q[0]);
        in_tvalid <= 1'b1;
        weights_q.push_back(predict_weights(pixel_q[0]));
        if (!quiet_tail && $urandom_range(0, 9) == 0) src_gap <= $urandom_range(1, 14);
      end
    end
  end

  // monitor
  int sink_gap = 0;
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (weights_q.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected output word %h", out_tdata);
      end else begin
        weights_t exp_w;
        weights_t got;
        exp_w = weights_q.pop_front();
        got.wa = out_tdata[bcw_pkg::OUT_W-1:0];
        got.wb = out_tdata[2*bcw_pkg::OUT_W-1:bcw_pkg::OUT_W];
        got.wc = out_tdata[3*bcw_pkg::OUT_W-1:2*bcw_pkg::OUT_W];
        got.degen = out_tuser;
        if (got !== exp_w || out_tdata[bcw_pkg::OUT_DATA_W-1:3*bcw_pkg::OUT_W] !== '0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("mismatch: exp wa=%0d wb=%0d wc=%0d dg=%0b got wa=%0d wb=%0d wc=%0d dg=%0b",
                     exp_w.wa, exp_w.wb, exp_w.wc, exp_w.degen,
                     got.wa, got.wb, got.wc, got.degen);
        end
      end
    end
    if (hold_sink) begin
      out_tready <= 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap <= sink_gap - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if (!quiet_tail && $urandom_range(0, 9) == 0) sink_gap <= $urandom_range(1, 14);
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("[barycentric_weights_core] ERROR");
      $finish;
    end
  end

  // stimulus
  initial begin
    int k;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    // directed: extremes, degenerate cases, saturation
    pixel_q.push_back(make_pixel(0, 0, 0, 0, 160, 0, 0, 160));
    pixel_q.push_back(make_pixel(10, 0, 0, 0, 160, 0, 0, 160));
    pixel_q.push_back(make_pixel(0, 10, 0, 0, 160, 0, 0, 160));
    pixel_q.push_back(make_pixel(3, 3, 0, 0, 160, 0, 0, 160));
    pixel_q.push_back(make_pixel(5, 5, 16, 16, 16, 16, 50, 80));
    pixel_q.push_back(make_pixel(5, 5, 0, 0, 32, 32, 64, 64));
    pixel_q.push_back(make_pixel(7, 7, 8, 8, 8, 8, 8, 8));
    pixel_q.push_back(make_pixel(2047, 2047, 0, 0, 1, 0, 0, 1));
    pixel_q.push_back(make_pixel(2047, 0, 0, 0, 1, 0, 0, 1));
    pixel_q.push_back(make_pixel(0, 2047, 0, 0, 1, 0, 0, 1));
    pixel_q.push_back(make_pixel(2047, 2047, -32768, -32768, 32767, -32768, -32768, 32767));
    pixel_q.push_back(make_pixel(0, 0, 32767, 32767, -32768, 32767, 32767, -32768));
    pixel_q.push_back(make_pixel(2047, 2047, 32767, -32768, -32768, 32767, 32767, 32767));
    pixel_q.push_back(make_pixel(1024, 1024, -32768, 32767, 32767, -32768, -32768, -32768));
    pixel_q.push_back(make_pixel(0, 0, 32767, 32767, 32767, 32767, -32768, -32768));
    pixel_q.push_back(make_pixel(100, 100, 0, 0, 1, 0, 0, -1));
    pixel_q.push_back(make_pixel(2047, 1, 0, 0, -1, 0, 0, 1));
    pixel_q.push_back(make_pixel(2047, 2047, 0, 0, 0, 0, 0, 0));
    pixel_q.push_back(make_pixel(1365, 682, -21846, 21845, 10922, -10923, 5461, 27306));
    // random noise and well-formed small triangles
    for (k = 0; k < 130; k++) begin
      if ($urandom_range(0, 3) == 0)
        pixel_q.push_back(make_pixel($urandom_range(0, 2047), $urandom_range(0, 2047),
          $urandom, $urandom, $urandom, $urandom, $urandom, $urandom));
      else
        pixel_q.push_back(rand_tri_pixel());
    end
    // long receiver hold-off so the pipeline fills and stalls the input
    wait (pixel_q.size() == 0 && !in_tvalid);
    hold_sink = 1'b1;
    for (k = 0; k < 80; k++) pixel_q.push_back(rand_tri_pixel());
    repeat (300) @(posedge clk);
    hold_sink = 1'b0;
    // sender pauses until everything has drained
    wait (pixel_q.size() == 0 && !in_tvalid);
    hold_src = 1'b1;
    wait (weights_q.size() == 0);
    hold_src = 1'b0;
    for (k = 0; k < 130; k++) pixel_q.push_back(rand_tri_pixel());
    wait (pixel_q.size() == 0 && !in_tvalid);
    quiet_tail = 1'b1;
    for (k = 0; k < 60; k++) begin
      if (k % 3 == 0)
        pixel_q.push_back(make_pixel($urandom_range(0, 2047), $urandom_range(0, 2047),
          $urandom, $urandom, $urandom, $urandom, $urandom, $urandom));
      else
        pixel_q.push_back(rand_tri_pixel());
    end
    wait (pixel_q.size() == 0 && !in_tvalid);
    wait (weights_q.size() == 0);
    repeat (40) @(posedge clk);
    if (mismatches == 0 && weights_q.size() == 0) begin
      $display("[barycentric_weights_core] OK");
    end else begin
      $display("[barycentric_weights_core] ERROR");
    end
    $finish;
  end

endmodule
